// ===== rtl/assert_macros.svh =====
// assertion macros shared by the mixer rtl
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SPGM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define SPGM_ASSERT_NEXT(label, pre, post, msg) \
  `SPGM_ASSERT(label, pre |=> post, msg)

`endif

// ===== rtl/spgm_pkg.sv =====
// shared types and constants of the stereo pan gain mixer
// no dependencies
package spgm_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SETTING_W  = 32;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned SCALED_W   = 32;
  localparam int unsigned PROD_W     = 46;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned MIX_W      = 49;
  localparam int unsigned QUOT_W     = 18;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PIPE_DEPTH = 6;

  localparam int unsigned STEREO_SHIFT = 30;
  localparam int unsigned MONO_SHIFT   = 31;

  localparam logic [GAIN_W-1:0] UNITY = 17'd32768;

  // floor(q / 3) = (q * RECIP3) >> RECIP3_SHIFT for q below 2^19
  localparam int unsigned       RECIP3_W     = 19;
  localparam int unsigned       RECIP3_SHIFT = 20;
  localparam logic [RECIP3_W-1:0] RECIP3     = 19'd349526;

  localparam logic [SETTING_W-1:0] CHAN_SETTING_RST = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAN0     = 3'd0,
    CFG_CHAN1     = 3'd1,
    CFG_CHAN2     = 3'd2,
    CFG_CHAN3     = 3'd3,
    CFG_ACTIVE    = 3'd4,
    CFG_NORMALIZE = 3'd5,
    CFG_STEREO    = 3'd6
  } cfg_reg_e;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic               stereo;
    logic               normalize;
    logic [COUNT_W-1:0] count;
  } mix_ctrl_t;

endpackage

// ===== rtl/spgm_lane.sv =====
// one mixer lane: volume scaling, then left and right pan gain products
// depends on spgm_pkg
module spgm_lane (
  input  logic                                 clk_i,
  input  logic                                 adv_i,
  input  logic                                 enable_i,
  input  logic signed [spgm_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic        [spgm_pkg::SETTING_W-1:0] setting_i,
  output spgm_pkg::prod_t                      prod_l_o,
  output spgm_pkg::prod_t                      prod_r_o
);

  logic        [spgm_pkg::GAIN_W-1:0]   vol_eff;
  logic        [spgm_pkg::GAIN_W-1:0]   gain_l_d, gain_r_d;
  logic        [spgm_pkg::GAIN_W-1:0]   gain_l_q, gain_r_q;
  logic        [spgm_pkg::GAIN_W-1:0]   pan_ext;
  logic signed [spgm_pkg::GAIN_W:0]     vol_s;
  logic signed [33:0]                   scaled_full;
  logic signed [spgm_pkg::SCALED_W-1:0] scaled_d, scaled_q;
  logic signed [spgm_pkg::GAIN_W:0]     gain_l_s, gain_r_s;
  logic signed [49:0]                   prod_l_full, prod_r_full;
  spgm_pkg::prod_t                      prod_l_q, prod_r_q;

  always_comb begin
    vol_eff = ({1'b0, setting_i[31:16]} > spgm_pkg::UNITY) ? spgm_pkg::UNITY
                                                          : {1'b0, setting_i[31:16]};
    pan_ext = {setting_i[15], setting_i[15:0]};
    if (setting_i[15]) begin
      gain_l_d = spgm_pkg::UNITY;
      gain_r_d = spgm_pkg::UNITY + pan_ext;
    end else begin
      gain_l_d = spgm_pkg::UNITY - pan_ext;
      gain_r_d = spgm_pkg::UNITY;
    end
    vol_s       = {1'b0, vol_eff};
    scaled_full = sample_i * vol_s;
    scaled_d    = enable_i ? scaled_full[spgm_pkg::SCALED_W-1:0] : '0;
  end

  always_comb begin
    gain_l_s    = {1'b0, gain_l_q};
    gain_r_s    = {1'b0, gain_r_q};
    prod_l_full = scaled_q * gain_l_s;
    prod_r_full = scaled_q * gain_r_s;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      scaled_q <= scaled_d;
      gain_l_q <= gain_l_d;
      gain_r_q <= gain_r_d;
      prod_l_q <= prod_l_full[spgm_pkg::PROD_W-1:0];
      prod_r_q <= prod_r_full[spgm_pkg::PROD_W-1:0];
    end
  end

  assign prod_l_o = prod_l_q;
  assign prod_r_o = prod_r_q;

endmodule

// ===== rtl/spgm_merge.sv =====
// merging stages: lane sums, mono fold, scale down, divide by count, saturate
// depends on spgm_pkg
module spgm_merge (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  spgm_pkg::mix_ctrl_t                 ctrl_i,
  input  spgm_pkg::prod_t                     prod_l_i [spgm_pkg::LANES],
  input  spgm_pkg::prod_t                     prod_r_i [spgm_pkg::LANES],
  output logic signed [spgm_pkg::SAMPLE_W-1:0] left_o,
  output logic signed [spgm_pkg::SAMPLE_W-1:0] right_o
);

  function automatic logic [spgm_pkg::QUOT_W-1:0] div_count(
    input logic [spgm_pkg::QUOT_W-1:0]  q,
    input logic [spgm_pkg::COUNT_W-1:0] d
  );
    logic [spgm_pkg::QUOT_W+spgm_pkg::RECIP3_W-1:0] p;
    logic [spgm_pkg::QUOT_W-1:0]                    r;
    p = q * spgm_pkg::RECIP3;
    case (d)
      3'd2:    r = q >> 1;
      3'd3:    r = p[spgm_pkg::RECIP3_SHIFT +: spgm_pkg::QUOT_W];
      3'd4:    r = q >> 2;
      default: r = q;
    endcase
    return r;
  endfunction

  function automatic logic signed [spgm_pkg::SAMPLE_W-1:0] sat16(
    input logic                        neg,
    input logic [spgm_pkg::QUOT_W-1:0] mag
  );
    logic [spgm_pkg::QUOT_W-1:0]          negm;
    logic signed [spgm_pkg::SAMPLE_W-1:0] r;
    negm = ~mag + 1'b1;
    if (neg) begin
      r = (mag > 18'd32768) ? 16'sh8000 : negm[spgm_pkg::SAMPLE_W-1:0];
    end else begin
      r = (mag > 18'd32767) ? 16'sh7fff : mag[spgm_pkg::SAMPLE_W-1:0];
    end
    return r;
  endfunction

  logic signed [spgm_pkg::SUM_W-1:0]   sum_l_d, sum_r_d, sum_l_q, sum_r_q;
  logic signed [spgm_pkg::MIX_W-1:0]   mix_l, mix_r;
  logic        [spgm_pkg::MIX_W-1:0]   mag_l, mag_r, shf_l, shf_r;
  logic        [spgm_pkg::QUOT_W-1:0]  q_l_q, q_r_q, quot_l_q, quot_r_q;
  logic                                neg_l_q, neg_r_q, sgn_l_q, sgn_r_q;
  logic        [spgm_pkg::COUNT_W-1:0] divisor;
  logic signed [spgm_pkg::SAMPLE_W-1:0] left_q, right_q;

  always_comb begin
    sum_l_d = '0;
    sum_r_d = '0;
    for (int i = 0; i < spgm_pkg::LANES; i++) begin
      sum_l_d = sum_l_d + spgm_pkg::SUM_W'(prod_l_i[i]);
      sum_r_d = sum_r_d + spgm_pkg::SUM_W'(prod_r_i[i]);
    end
  end

  always_comb begin
    if (ctrl_i.stereo) begin
      mix_l = spgm_pkg::MIX_W'(sum_l_q);
      mix_r = spgm_pkg::MIX_W'(sum_r_q);
    end else begin
      mix_l = spgm_pkg::MIX_W'(sum_l_q) + spgm_pkg::MIX_W'(sum_r_q);
      mix_r = '0;
    end
    mag_l = mix_l[spgm_pkg::MIX_W-1] ? -mix_l : mix_l;
    mag_r = mix_r[spgm_pkg::MIX_W-1] ? -mix_r : mix_r;
    shf_l = ctrl_i.stereo ? (mag_l >> spgm_pkg::STEREO_SHIFT) : (mag_l >> spgm_pkg::MONO_SHIFT);
    shf_r = ctrl_i.stereo ? (mag_r >> spgm_pkg::STEREO_SHIFT) : (mag_r >> spgm_pkg::MONO_SHIFT);
    divisor = (ctrl_i.normalize && (ctrl_i.count != '0)) ? ctrl_i.count : 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_l_q  <= sum_l_d;
      sum_r_q  <= sum_r_d;
      q_l_q    <= shf_l[spgm_pkg::QUOT_W-1:0];
      q_r_q    <= shf_r[spgm_pkg::QUOT_W-1:0];
      neg_l_q  <= mix_l[spgm_pkg::MIX_W-1];
      neg_r_q  <= mix_r[spgm_pkg::MIX_W-1];
      quot_l_q <= div_count(q_l_q, divisor);
      quot_r_q <= div_count(q_r_q, divisor);
      sgn_l_q  <= neg_l_q;
      sgn_r_q  <= neg_r_q;
      left_q   <= sat16(sgn_l_q, quot_l_q);
      right_q  <= sat16(sgn_r_q, quot_r_q);
    end
  end

  assign left_o  = left_q;
  assign right_o = right_q;

endmodule

// ===== rtl/stereo_pan_gain_mixer_core.sv =====
// Four-channel audio mixer with per-channel volume and linear pan.
//
// Input stream (s_axis): one word per frame, four signed 16-bit samples in
// tdata and the mask of channels that carry a sample in tuser. Output stream
// (m_axis): one word per frame with the left and right mix in tdata.
// Configuration channel (cfg_*): register index and 32-bit data, always
// ready; a write lands at the edge where cfg_valid_i is high. Registers are
// channel settings 0..3 (volume in 31:16, pan in 15:0), active mask,
// normalize enable and stereo mode. Write them only while no frame is in
// flight.
// Six register stages, the first loaded at the edge that accepts a word; one
// frame is taken per cycle while the output does not stall. The lanes scale
// and pan each channel in two multiplier stages; the merge adds the lanes,
// folds mono, scales down, divides by the active count when normalize is on
// (shifts for two and four, a reciprocal multiply for three) and saturates.
// Reset clears the pipeline valid bits, loads register defaults (unity volume,
// center pan, no active channels, stereo). When m_axis_tready is low with a
// result waiting, the whole pipeline holds and s_axis_tready drops.
// depends on spgm_pkg, spgm_lane, spgm_merge and assert_macros.svh
`include "assert_macros.svh"

module stereo_pan_gain_mixer_core #(
  parameter int unsigned CHAN_CNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_ch0, sample_ch1, sample_ch2, sample_ch3
  input  logic [63:0] s_axis_tdata,
  // present_mask
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_out, right_out
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [spgm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spgm_pkg::SETTING_W-1:0] cfg_data_i
);

  localparam logic [spgm_pkg::LANES-1:0] LANE_MASK =
    spgm_pkg::LANES'((1 << CHAN_CNT) - 1);

  logic [spgm_pkg::SETTING_W-1:0] chan_setting_q [spgm_pkg::LANES];
  logic [spgm_pkg::LANES-1:0]     active_q, active_eff;
  logic                           normalize_q, stereo_q;
  logic [spgm_pkg::PIPE_DEPTH-1:0] valid_q;
  logic                           adv;
  spgm_pkg::mix_ctrl_t            ctrl;
  spgm_pkg::prod_t                prod_l [spgm_pkg::LANES];
  spgm_pkg::prod_t                prod_r [spgm_pkg::LANES];
  logic signed [spgm_pkg::SAMPLE_W-1:0] left, right;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spgm_pkg::LANES; i++) begin
        chan_setting_q[i] <= spgm_pkg::CHAN_SETTING_RST;
      end
      active_q    <= '0;
      normalize_q <= 1'b0;
      stereo_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spgm_pkg::CFG_CHAN0:     chan_setting_q[0] <= cfg_data_i;
        spgm_pkg::CFG_CHAN1:     chan_setting_q[1] <= cfg_data_i;
        spgm_pkg::CFG_CHAN2:     chan_setting_q[2] <= cfg_data_i;
        spgm_pkg::CFG_CHAN3:     chan_setting_q[3] <= cfg_data_i;
        spgm_pkg::CFG_ACTIVE:    active_q    <= cfg_data_i[spgm_pkg::LANES-1:0];
        spgm_pkg::CFG_NORMALIZE: normalize_q <= cfg_data_i[0];
        spgm_pkg::CFG_STEREO:    stereo_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv           = !valid_q[spgm_pkg::PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = valid_q[spgm_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[spgm_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  assign active_eff     = active_q & LANE_MASK;
  assign ctrl.stereo    = stereo_q;
  assign ctrl.normalize = normalize_q;
  assign ctrl.count     = spgm_pkg::COUNT_W'($countones(active_eff));

  for (genvar i = 0; i < spgm_pkg::LANES; i++) begin : g_lane
    if (i < CHAN_CNT) begin : g_on
      spgm_lane u_lane (
        .clk_i     (clk_i),
        .adv_i     (adv),
        .enable_i  (active_eff[i] & s_axis_tuser[i]),
        .sample_i  (s_axis_tdata[i*spgm_pkg::SAMPLE_W +: spgm_pkg::SAMPLE_W]),
        .setting_i (chan_setting_q[i]),
        .prod_l_o  (prod_l[i]),
        .prod_r_o  (prod_r[i])
      );
    end else begin : g_off
      assign prod_l[i] = '0;
      assign prod_r[i] = '0;
    end
  end

  spgm_merge u_merge (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .ctrl_i   (ctrl),
    .prod_l_i (prod_l),
    .prod_r_i (prod_r),
    .left_o   (left),
    .right_o  (right)
  );

  assign m_axis_tdata = {right, left};

  `SPGM_ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable(valid_q), "pipeline moved while stalled")
  `SPGM_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, valid_q[0], "accepted word lost")
  `SPGM_ASSERT_NEXT(a_no_repeat, m_axis_tvalid && m_axis_tready && !valid_q[spgm_pkg::PIPE_DEPTH-2], !m_axis_tvalid, "result word repeated")

endmodule
